[rtl/dct_pkg.sv]
// Shared types, constants and helpers for the DSL character tokenizer.
package dct_pkg;

  localparam int LINE_BITS  = 24;
  localparam int INT_BITS   = 31;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [INT_BITS-1:0] INT_MAX = {INT_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;

  typedef enum logic [4:0] {
    K_EOF    = 5'd0,
    K_AT     = 5'd1,
    K_RCURLY = 5'd2,
    K_LCURLY = 5'd3,
    K_SEMI   = 5'd4,
    K_RPAREN = 5'd5,
    K_LPAREN = 5'd6,
    K_COMMA  = 5'd7,
    K_COLON  = 5'd8,
    K_EQUAL  = 5'd9,
    K_PIPE   = 5'd10,
    K_DOLLAR = 5'd11,
    K_DASH   = 5'd12,
    K_AMP    = 5'd13,
    K_INT    = 5'd14,
    K_LETTER = 5'd15,
    K_ERROR  = 5'd16
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNEXPECTED = 2'd1,
    ERR_OPEN_BRACK = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_BRACKET = 3'd2,
    MODE_NUMBER  = 3'd3,
    MODE_WORD    = 3'd4,
    MODE_DONE    = 3'd5
  } mode_t;

  typedef struct packed {
    kind_t                kind;
    logic [INT_BITS-1:0]  int_value;
    logic [7:0]           letter;
    logic                 word_start;
    logic [LINE_BITS-1:0] line_number;
    err_t                 error_code;
    logic                 last;
  } res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // K_EOF means "not a punctuation character"
  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_AT:     k = K_AT;
      CH_RCURLY: k = K_RCURLY;
      CH_LCURLY: k = K_LCURLY;
      CH_SEMI:   k = K_SEMI;
      CH_RPAREN: k = K_RPAREN;
      CH_LPAREN: k = K_LPAREN;
      CH_COMMA:  k = K_COMMA;
      CH_COLON:  k = K_COLON;
      CH_EQUAL:  k = K_EQUAL;
      CH_PIPE:   k = K_PIPE;
      CH_DOLLAR: k = K_DOLLAR;
      CH_DASH:   k = K_DASH;
      CH_AMP:    k = K_AMP;
      default:   k = K_EOF;
    endcase
    return k;
  endfunction

endpackage

[rtl/dct_ifs.sv]
// Channel interfaces: character input and token output.
interface dct_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source(output valid, char_code, end_of_text, input ready);
  modport sink(input valid, char_code, end_of_text, output ready);
endinterface

interface dct_tok_if import dct_pkg::*; ();
  logic                 valid;
  logic                 ready;
  kind_t                kind;
  logic [INT_BITS-1:0]  int_value;
  logic [7:0]           letter;
  logic                 word_start;
  logic [LINE_BITS-1:0] line_number;
  err_t                 error_code;
  logic                 last;

  modport source(output valid, kind, int_value, letter, word_start, line_number,
                 error_code, last, input ready);
  modport sink(input valid, kind, int_value, letter, word_start, line_number,
               error_code, last, output ready);
endinterface

[rtl/dsl_char_tokenizer.sv]
// Top level of the DSL character tokenizer.
//
//  channel   dir  payload                                           handshake
//  char_in   in   char_code, end_of_text                            valid/ready
//  tok_out   out  kind, int_value, letter, word_start, line_number,  valid/ready
//                 error_code, last
//
// One character per cycle: the scan logic runs in the cycle of the transfer
// and writes zero, one or two results into a 4-entry result queue.
// char_in.ready is high while the queue has room for two results, so input
// only stalls when tok_out is held off; a character that makes two results
// is shown as two tokens in turn. Results are registered in the queue.
// Synchronous reset empties the queue and returns to normal mode, line 1.
module dsl_char_tokenizer import dct_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  dct_char_if.sink       char_in,
  dct_tok_if.source      tok_out
);

  mode_t                mode, mode_next;
  logic [INT_BITS-1:0]  acc, acc_next;
  logic [LINE_BITS-1:0] line_count, line_next;

  res_t                 fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]   count;

  logic                 in_xfer, out_xfer;
  logic [1:0]           n_res;
  res_t                 res0, res1;

  // normal-mode handling of the current character
  logic                 nm_emit, nm_bump;
  kind_t                nm_kind;
  err_t                 nm_err;
  logic                 nm_start;
  mode_t                nm_mode;

  logic [7:0]           c;
  logic                 eot;
  logic [INT_BITS+3:0]  acc_mul;
  logic                 line_bump;
  logic [LINE_BITS-1:0] line_inc;

  assign c   = char_in.char_code;
  assign eot = char_in.end_of_text;

  assign in_xfer  = char_in.valid && char_in.ready;
  assign out_xfer = tok_out.valid && tok_out.ready;
  assign char_in.ready = count <= FIFO_CW'(FIFO_DEPTH - 2);

  assign acc_mul = {3'b000, acc, 1'b0} + {acc, 3'b000} + (INT_BITS+4)'(c - CH_ZERO);
  assign line_inc = (line_count != LINE_MAX) ? line_count + LINE_ONE : line_count;

  always_comb begin
    nm_emit  = 1'b0;
    nm_bump  = 1'b0;
    nm_kind  = K_EOF;
    nm_err   = ERR_NONE;
    nm_start = 1'b0;
    nm_mode  = MODE_NORMAL;
    if (eot) begin
      nm_emit = 1'b1;
      nm_mode = MODE_DONE;
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
      nm_mode = MODE_NORMAL;
    end else if (c == CH_LF) begin
      nm_bump = 1'b1;
    end else if (c == CH_HASH) begin
      nm_mode = MODE_COMMENT;
    end else if (c == CH_LBRACK) begin
      nm_mode = MODE_BRACKET;
    end else if (punct_kind(c) != K_EOF) begin
      nm_emit = 1'b1;
      nm_kind = punct_kind(c);
    end else if (is_digit(c)) begin
      nm_mode = MODE_NUMBER;
    end else if (is_letter(c)) begin
      nm_emit  = 1'b1;
      nm_kind  = K_LETTER;
      nm_start = 1'b1;
      nm_mode  = MODE_WORD;
    end else begin
      nm_emit = 1'b1;
      nm_kind = K_ERROR;
      nm_err  = ERR_UNEXPECTED;
      nm_mode = MODE_DONE;
    end
  end

  // scan state machine: next state and results of the accepted character
  always_comb begin
    res_t base, nm_res;
    base            = '0;
    base.kind       = K_EOF;
    base.error_code = ERR_NONE;
    base.line_number = line_count;
    nm_res            = base;
    nm_res.kind       = nm_kind;
    nm_res.error_code = nm_err;
    nm_res.word_start = nm_start;
    nm_res.letter     = nm_kind == K_LETTER ? c : 8'h00;

    mode_next = mode;
    acc_next  = acc;
    line_bump = 1'b0;
    n_res     = 2'd0;
    res0      = base;
    res1      = base;

    case (mode)
      MODE_NORMAL: begin
        mode_next = nm_mode;
        line_bump = nm_bump;
        acc_next  = INT_BITS'(c - CH_ZERO);
        res0      = nm_res;
        n_res     = {1'b0, nm_emit};
      end
      MODE_COMMENT: begin
        if (eot) begin
          mode_next = MODE_DONE;
          n_res     = 2'd1;
        end else if (c == CH_LF) begin
          line_bump = 1'b1;
          mode_next = MODE_NORMAL;
        end
      end
      MODE_BRACKET: begin
        if (eot) begin
          mode_next       = MODE_DONE;
          res0.kind       = K_ERROR;
          res0.error_code = ERR_OPEN_BRACK;
          n_res           = 2'd1;
        end else if (c == CH_LF) begin
          line_bump = 1'b1;
        end else if (c == CH_RBRACK) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_NUMBER: begin
        if (!eot && is_digit(c)) begin
          acc_next = (acc_mul > (INT_BITS+4)'(INT_MAX)) ? INT_MAX : acc_mul[INT_BITS-1:0];
        end else begin
          // terminator gives the int token, then is scanned as a normal char
          acc_next       = '0;
          res0.kind      = K_INT;
          res0.int_value = acc;
          res1           = nm_res;
          mode_next      = nm_mode;
          line_bump      = nm_bump;
          n_res          = nm_emit ? 2'd2 : 2'd1;
        end
      end
      MODE_WORD: begin
        if (!eot && is_letter(c)) begin
          res0.kind   = K_LETTER;
          res0.letter = c;
          n_res       = 2'd1;
        end else begin
          mode_next = nm_mode;
          line_bump = nm_bump;
          acc_next  = INT_BITS'(c - CH_ZERO);
          res0      = nm_res;
          n_res     = {1'b0, nm_emit};
        end
      end
      default: begin
        mode_next = MODE_DONE;
      end
    endcase

    res0.last = n_res == 2'd1;
    res1.last = 1'b1;
    line_next = line_bump ? line_inc : line_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      acc        <= '0;
      line_count <= LINE_ONE;
    end else if (in_xfer) begin
      mode       <= mode_next;
      acc        <= acc_next;
      line_count <= line_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + FIFO_AW'(n_res);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(in_xfer ? n_res : 2'd0) - FIFO_CW'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && n_res != 2'd0) begin
      fifo[wr_ptr] <= res0;
    end
    if (in_xfer && n_res == 2'd2) begin
      fifo[wr_ptr + FIFO_AW'(1)] <= res1;
    end
  end

  assign tok_out.valid       = count != '0;
  assign tok_out.kind        = fifo[rd_ptr].kind;
  assign tok_out.int_value   = fifo[rd_ptr].int_value;
  assign tok_out.letter      = fifo[rd_ptr].letter;
  assign tok_out.word_start  = fifo[rd_ptr].word_start;
  assign tok_out.line_number = fifo[rd_ptr].line_number;
  assign tok_out.error_code  = fifo[rd_ptr].error_code;
  assign tok_out.last        = fifo[rd_ptr].last;

endmodule

[rtl/dct_checker.sv]
// Port-level checks for the DSL character tokenizer, bound to the top level.
module dct_checker import dct_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input kind_t                kind,
  input logic [INT_BITS-1:0]  int_value,
  input logic [7:0]           letter,
  input logic                 word_start,
  input logic [LINE_BITS-1:0] line_number,
  input err_t                 error_code,
  input logic                 last
);

  logic out_xfer;
  logic done_seen;

  assign out_xfer = out_valid && out_ready;

  // set once an eof or error token has been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      done_seen <= 1'b0;
    end else if (out_xfer && (kind == K_EOF || kind == K_ERROR)) begin
      done_seen <= 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(int_value)
      && $stable(letter) && $stable(line_number) && $stable(last))
    else $error("stalled result changed");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == K_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match kind");

  a_terminal: assert property (@(posedge clk) disable iff (rst)
    done_seen |-> !out_valid)
    else $error("result after eof or error");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == K_EOF || kind == K_ERROR || word_start) |->
      (last || word_start) && (!word_start || kind == K_LETTER))
    else $error("terminal token not last, or word start on non-letter");

endmodule

bind dsl_char_tokenizer dct_checker u_dct_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (tok_out.valid),
  .out_ready   (tok_out.ready),
  .kind        (tok_out.kind),
  .int_value   (tok_out.int_value),
  .letter      (tok_out.letter),
  .word_start  (tok_out.word_start),
  .line_number (tok_out.line_number),
  .error_code  (tok_out.error_code),
  .last        (tok_out.last)
);
